// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pulse encoder.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RFPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a second one in the same cycle.
`define RFPE_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

`endif

// ===== hdl/rfpe_pkg.sv =====
// Types, segment codes, register indexes and reset values of the pulse encoder.
// No dependencies; used by the channel interface users and the top level.
package rfpe_pkg;

    // Frame segments
    typedef enum logic [3:0] {
        SEG_IDLE     = 4'd0,
        SEG_START_HI = 4'd1,
        SEG_START_LO = 4'd2,
        SEG_BIT_HI1  = 4'd3,
        SEG_BIT_LO1  = 4'd4,
        SEG_BIT_HI2  = 4'd5,
        SEG_BIT_LO2  = 4'd6,
        SEG_STOP_HI  = 4'd7,
        SEG_END_LO   = 4'd8
    } t_seg;

    // Item operations
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_REPEAT = 3'd5;

    // Field widths
    localparam int TICK_W   = 16;
    localparam int REPEAT_W = 4;
    localparam int ID_W     = 26;
    localparam int SWITCH_W = 4;
    localparam int PACK_W   = ID_W + 2 + SWITCH_W;

    // Register reset values
    localparam logic [TICK_W-1:0]   RST_HIGH_PULSE = 16'd250;
    localparam logic [TICK_W-1:0]   RST_START_GAP  = 16'd2600;
    localparam logic [TICK_W-1:0]   RST_SHORT_GAP  = 16'd280;
    localparam logic [TICK_W-1:0]   RST_LONG_GAP   = 16'd1150;
    localparam logic [TICK_W-1:0]   RST_END_GAP    = 16'd10000;
    localparam logic [REPEAT_W-1:0] RST_DEF_REPEAT = 4'd3;

    // Input item
    typedef struct packed {
        logic                op;
        logic [ID_W-1:0]     remote_id;
        logic                group_flag;
        logic                on_flag;
        logic [SWITCH_W-1:0] switch_id;
        logic [REPEAT_W-1:0] repeat_count;
    } t_req;

    // Result item
    typedef struct packed {
        logic pin_level;
        logic busy_res;
    } t_res;

    // Configuration write
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [TICK_W-1:0]    data;
    } t_cfg;

    // Pin level driven during a segment
    function automatic logic seg_is_high(t_seg seg);
        return (seg == SEG_START_HI) || (seg == SEG_BIT_HI1) ||
               (seg == SEG_BIT_HI2) || (seg == SEG_STOP_HI);
    endfunction

endpackage

// ===== hdl/rfpe_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// No dependencies; payload types come from rfpe_pkg at instantiation.
interface rfpe_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/rf_remote_pulse_encoder.sv =====
// On-off-keyed remote-control frame encoder, top level.
// Depends on rfpe_pkg, rfpe_if and assert_macros.svh.
//
//  channel  | dir | payload | transfer
//  ---------+-----+---------+--------------------------------------------
//  i_req    | in  | t_req   | tick or send request, valid & ready
//  o_res    | out | t_res   | pin level and busy flag, valid & ready
//  i_cfg    | in  | t_cfg   | register write, always ready
//
// One item per clock cycle while i_req.ready is high; its result is registered in the
// output register, or in the skid register while o_res stalls. The frame timer, bit pointer
// and segment state update on the edge of the transfer. An output register plus a skid
// register decouple the two sides; i_req.ready drops only while the skid register holds a result.
// Reset (synchronous, active low) loads the register defaults and goes idle.
`include "assert_macros.svh"

module rf_remote_pulse_encoder import rfpe_pkg::*; #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rfpe_if.sink   i_req,
    rfpe_if.source o_res,
    rfpe_if.sink   i_cfg
);

    localparam int IDX_W = $clog2(WORD_BITS);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(WORD_BITS - 1);

    // Configuration registers
    logic [TICK_W-1:0]   r_high_pulse, r_start_gap, r_short_gap, r_long_gap, r_end_gap;
    logic [REPEAT_W-1:0] r_def_repeat;

    // Frame state
    logic [WORD_BITS-1:0] r_word,   n_word;
    logic [IDX_W-1:0]     r_bit,    n_bit;
    t_seg                 r_seg,    n_seg;
    logic [TICK_W-1:0]    r_tick,   n_tick;
    logic [REPEAT_W-1:0]  r_rep,    n_rep;
    logic                 r_active, n_active;

    // Output and skid registers
    logic r_out_valid, r_skid_valid;
    t_res r_out_data,  r_skid_data;

    logic                 req_xfer, cfg_xfer, out_pop;
    logic [REPEAT_W-1:0]  start_count;
    logic [PACK_W-1:0]    packed_word;
    logic                 cur_bit;
    logic [TICK_W-1:0]    seg_len, tick_inc;
    t_res                 res;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_skid_valid;
    assign out_pop     = !r_out_valid || o_res.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out_data;

    // Register writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pulse <= RST_HIGH_PULSE;
            r_start_gap  <= RST_START_GAP;
            r_short_gap  <= RST_SHORT_GAP;
            r_long_gap   <= RST_LONG_GAP;
            r_end_gap    <= RST_END_GAP;
            r_def_repeat <= RST_DEF_REPEAT;
        end else if (cfg_xfer) begin
            case (i_cfg.payload.index)
                CFG_HIGH_PULSE: r_high_pulse <= i_cfg.payload.data;
                CFG_START_GAP:  r_start_gap  <= i_cfg.payload.data;
                CFG_SHORT_GAP:  r_short_gap  <= i_cfg.payload.data;
                CFG_LONG_GAP:   r_long_gap   <= i_cfg.payload.data;
                CFG_END_GAP:    r_end_gap    <= i_cfg.payload.data;
                CFG_DEF_REPEAT: r_def_repeat <= i_cfg.payload.data[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Request word and frame count
    assign packed_word = {i_req.payload.remote_id, i_req.payload.group_flag,
                          i_req.payload.on_flag, i_req.payload.switch_id};
    assign start_count = (i_req.payload.repeat_count != '0) ?
                         i_req.payload.repeat_count : r_def_repeat;

    // Length of the running segment, MSB-first bit select
    assign cur_bit  = r_word[LAST_BIT - r_bit];
    assign tick_inc = r_tick + TICK_W'(1);

    always_comb begin
        case (r_seg)
            SEG_START_LO: seg_len = r_start_gap;
            SEG_BIT_LO1:  seg_len = cur_bit ? r_long_gap : r_short_gap;
            SEG_BIT_LO2:  seg_len = cur_bit ? r_short_gap : r_long_gap;
            SEG_END_LO:   seg_len = r_end_gap;
            default:      seg_len = r_high_pulse;
        endcase
    end

    // Next state: start a frame on a send request while idle, advance the timer on a tick
    always_comb begin
        n_word   = r_word;
        n_bit    = r_bit;
        n_seg    = r_seg;
        n_tick   = r_tick;
        n_rep    = r_rep;
        n_active = r_active;
        if (req_xfer) begin
            if (i_req.payload.op == OP_SEND) begin
                if (!r_active && (start_count != '0)) begin
                    n_word   = WORD_BITS'(packed_word);
                    n_rep    = start_count;
                    n_bit    = '0;
                    n_tick   = '0;
                    n_seg    = SEG_START_HI;
                    n_active = 1'b1;
                end
            end else if (r_active) begin
                if ((tick_inc == '0) || (tick_inc >= seg_len)) begin
                    n_tick = '0;
                    case (r_seg)
                        SEG_START_HI: n_seg = SEG_START_LO;
                        SEG_START_LO: n_seg = SEG_BIT_HI1;
                        SEG_BIT_HI1:  n_seg = SEG_BIT_LO1;
                        SEG_BIT_LO1:  n_seg = SEG_BIT_HI2;
                        SEG_BIT_HI2:  n_seg = SEG_BIT_LO2;
                        SEG_BIT_LO2: begin
                            if (r_bit == LAST_BIT) begin
                                n_seg = SEG_STOP_HI;
                            end else begin
                                n_bit = r_bit + IDX_W'(1);
                                n_seg = SEG_BIT_HI1;
                            end
                        end
                        SEG_STOP_HI:  n_seg = SEG_END_LO;
                        default: begin
                            // end gap done: next frame or idle
                            n_rep = r_rep - REPEAT_W'(1);
                            n_bit = '0;
                            if (n_rep == '0) begin
                                n_active = 1'b0;
                                n_seg    = SEG_IDLE;
                            end else begin
                                n_seg    = SEG_START_HI;
                            end
                        end
                    endcase
                end else begin
                    n_tick = tick_inc;
                end
            end
        end
    end

    // Result: a tick reports the level it drives, a request the coming level
    always_comb begin
        if (i_req.payload.op == OP_SEND) begin
            res.pin_level = n_active && seg_is_high(n_seg);
            res.busy_res  = n_active;
        end else begin
            res.pin_level = r_active && seg_is_high(r_seg);
            res.busy_res  = r_active;
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word   <= '0;
            r_bit    <= '0;
            r_seg    <= SEG_IDLE;
            r_tick   <= '0;
            r_rep    <= '0;
            r_active <= 1'b0;
        end else begin
            r_word   <= n_word;
            r_bit    <= n_bit;
            r_seg    <= n_seg;
            r_tick   <= n_tick;
            r_rep    <= n_rep;
            r_active <= n_active;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= req_xfer;
            end
        end else if (req_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (req_xfer) begin
                r_out_data <= res;
            end
        end else if (req_xfer) begin
            r_skid_data <= res;
        end
    end

    // Checks
    `RFPE_ASSERT_IMPL(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full while output empty")
    `RFPE_ASSERT_IMPL(a_idle_segment, !r_active, r_seg == SEG_IDLE, "idle with a live segment")
    `RFPE_ASSERT_IMPL(a_active_frames, r_active, r_rep != '0, "active with no frames left")
    `RFPE_ASSERT_IMPL(a_quiet_pin, o_res.valid && !o_res.payload.busy_res,
        !o_res.payload.pin_level, "pin high outside a transmission")

endmodule
